@@ sv/mbrtu_pkg.sv @@
package mbrtu_pkg;

   localparam int MaxFrameBytesDef = 256;
   localparam int StoreWordsDef    = 128;
   localparam int MaxReadCountDef  = 120;

   localparam logic [7:0]  FuncReadHolding = 8'h03;
   localparam logic [7:0]  FuncWriteSingle = 8'h06;
   localparam logic [7:0]  FuncWriteMulti  = 8'h10;
   localparam logic [8:0]  MinFrameBytes   = 9'd8;
   localparam logic [15:0] CrcInit         = 16'hFFFF;
   localparam logic [15:0] CrcPoly         = 16'hA001;

   localparam logic [1:0] ModeRxByte = 2'd0;
   localparam logic [1:0] ModeTick   = 2'd1;
   localparam logic [1:0] ModeTxSlot = 2'd2;
   localparam logic [1:0] ModeWrite  = 2'd3;

   localparam logic CsrDeviceAddress = 1'b0;
   localparam logic CsrSilenceTicks  = 1'b1;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  data_byte;
      logic [6:0]  store_index;
      logic [15:0] store_value;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
   } rsp_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
      end
      return r;
   endfunction

endpackage

@@ sv/mbrtu_ram.sv @@
module mbrtu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/modbus_rtu_read_register_slave_top.sv @@
// Channel | Ports                          | Moves
// --------+--------------------------------+------------------------------------
// request | req_valid, req_stall, req_payload | byte, tick, tx slot or store write
// result  | rsp_valid, rsp_stall, rsp_payload | one reply byte per tx slot
// config  | csr_we, csr_index, csr_data    | device address, silence ticks
//
// One request transfer per cycle while req_stall is low. A tx slot's byte passes
// through the byte stage, which also takes the store memory's registered read, and then the result register.
// Reset clears control state and the store valid bits; no clearing pass.
// A stalled result holds the byte stage, which then stalls the request side.
module modbus_rtu_read_register_slave_top
   import mbrtu_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = MaxFrameBytesDef,
   parameter int STORE_WORDS     = StoreWordsDef,
   parameter int MAX_READ_COUNT  = MaxReadCountDef
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_data
);

   localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

   localparam logic [2:0] KindConst  = 3'd0;
   localparam logic [2:0] KindDataHi = 3'd1;
   localparam logic [2:0] KindDataLo = 3'd2;
   localparam logic [2:0] KindCrcLo  = 3'd3;
   localparam logic [2:0] KindCrcHi  = 3'd4;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] const_byte;
      logic       in_range;
      logic       first;
      logic       last;
   } slot_type;

   // configuration
   logic [7:0] dev_addr_ff, silence_ticks_ff;

   // frame receive state
   logic       awaiting_ff, awaiting_in;
   logic [8:0] frame_len_ff, frame_len_in;
   logic [7:0] hdr_ff [6];
   logic [7:0] hdr_in [6];
   logic [7:0] sil_cnt_ff, sil_cnt_in;
   logic       timer_ff, timer_in;
   logic [15:0] crc_run_ff, crc_run_in;
   logic [7:0] tail0_ff, tail0_in, tail1_ff, tail1_in;

   // reply state
   logic        pend_ff, pend_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  raddr_byte_ff, raddr_byte_in;
   logic [15:0] rstart_ff, rstart_in;
   logic [7:0]  rcount_ff, rcount_in;
   logic [15:0] reply_crc_ff, reply_crc_in;

   // byte stage
   logic     slot_vld_ff, slot_vld_in;
   slot_type slot_ff, slot_in;
   logic     slot_adv, accept;

   // store
   logic [STORE_WORDS-1:0] wvalid_ff;
   logic                   vq_ff;
   logic                   rd_en, wr_en;
   logic [AW-1:0]          rd_addr;
   logic [AW-1:0]          wr_addr;
   logic [15:0]            ram_q;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   assign slot_adv  = slot_vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = slot_vld_ff && !slot_adv;
   assign accept    = req_valid && !req_stall;
   assign wr_addr   = AW'(req_payload.store_index);

   // request stage: frame and reply bookkeeping; the reply CRC runs in the byte stage
   always_comb begin
      logic        take;
      logic [7:0]  sc;
      logic [15:0] cnt;
      logic [8:0]  data_end;
      logic [7:0]  koff;
      logic [16:0] waddr_full;
      awaiting_in  = awaiting_ff;
      frame_len_in = frame_len_ff;
      for (int i = 0; i < 6; i++) hdr_in[i] = hdr_ff[i];
      sil_cnt_in   = sil_cnt_ff;
      timer_in     = timer_ff;
      crc_run_in   = crc_run_ff;
      tail0_in     = tail0_ff;
      tail1_in     = tail1_ff;
      pend_in      = pend_ff;
      pos_in       = pos_ff;
      raddr_byte_in = raddr_byte_ff;
      rstart_in    = rstart_ff;
      rcount_in    = rcount_ff;
      slot_vld_in  = slot_adv ? 1'b0 : slot_vld_ff;
      slot_in      = slot_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      take         = 1'b0;
      sc           = 8'd0;
      cnt          = {hdr_ff[4], hdr_ff[5]};
      data_end     = 9'd3 + {rcount_ff, 1'b0};
      koff         = (pos_ff - 8'd3) >> 1;
      waddr_full   = {1'b0, rstart_ff} + {9'd0, koff};
      rd_addr      = waddr_full[AW-1:0];
      if (accept) begin
         case (req_payload.mode)
            ModeRxByte: begin
               if (awaiting_ff) begin
                  if (req_payload.data_byte == dev_addr_ff) begin
                     take        = 1'b1;
                     awaiting_in = 1'b0;
                  end
               end else if (32'(frame_len_ff) < 32'(MAX_FRAME_BYTES)) begin
                  take = 1'b1;
               end
               if (take) begin
                  // a fresh frame restarts length, CRC and tail
                  if (awaiting_ff) begin
                     crc_run_in = CrcInit;
                     tail0_in   = 8'd0;
                     tail1_in   = 8'd0;
                     if (frame_len_ff != 9'd0) frame_len_in = 9'd0;
                  end
                  if (!awaiting_ff && frame_len_ff >= 9'd2) begin
                     crc_run_in = crc_feed(crc_run_ff, tail0_ff);
                  end
                  tail0_in = awaiting_ff ? 8'd0 : tail1_ff;
                  tail1_in = req_payload.data_byte;
                  if (awaiting_ff) begin
                     hdr_in[0]    = req_payload.data_byte;
                     frame_len_in = 9'd1;
                  end else begin
                     for (int i = 0; i < 6; i++) begin
                        if (frame_len_ff == 9'(i)) hdr_in[i] = req_payload.data_byte;
                     end
                     frame_len_in = frame_len_ff + 9'd1;
                  end
                  sil_cnt_in = 8'd0;
                  timer_in   = 1'b1;
               end
            end
            ModeTick: begin
               if (timer_ff) begin
                  sc = (sil_cnt_ff == 8'hFF) ? sil_cnt_ff : sil_cnt_ff + 8'd1;
                  sil_cnt_in = sc;
                  if (sc >= silence_ticks_ff) begin
                     timer_in     = 1'b0;
                     sil_cnt_in   = 8'd0;
                     awaiting_in  = 1'b1;
                     frame_len_in = 9'd0;
                     if (frame_len_ff >= MinFrameBytes
                           && crc_run_ff[7:0] == tail0_ff
                           && crc_run_ff[15:8] == tail1_ff
                           && hdr_ff[0] == dev_addr_ff
                           && hdr_ff[1] == FuncReadHolding
                           && 32'(cnt) <= 32'(MAX_READ_COUNT)) begin
                        raddr_byte_in = dev_addr_ff;
                        rstart_in     = {hdr_ff[2], hdr_ff[3]};
                        rcount_in     = cnt[7:0];
                        pos_in        = 8'd0;
                        pend_in       = 1'b1;
                     end
                  end
               end
            end
            ModeWrite: begin
               wr_en = 32'(req_payload.store_index) < 32'(STORE_WORDS);
            end
            ModeTxSlot: begin
               if (pend_ff) begin
                  slot_vld_in        = 1'b1;
                  slot_in.first      = (pos_ff == 8'd0);
                  slot_in.last       = 1'b0;
                  slot_in.const_byte = 8'd0;
                  slot_in.in_range   = 32'(waddr_full) < 32'(STORE_WORDS);
                  if (pos_ff == 8'd0) begin
                     slot_in.kind       = KindConst;
                     slot_in.const_byte = raddr_byte_ff;
                  end else if (pos_ff == 8'd1) begin
                     slot_in.kind       = KindConst;
                     slot_in.const_byte = FuncReadHolding;
                  end else if (pos_ff == 8'd2) begin
                     slot_in.kind       = KindConst;
                     slot_in.const_byte = {rcount_ff[6:0], 1'b0};
                  end else if ({1'b0, pos_ff} < data_end) begin
                     slot_in.kind = pos_ff[0] ? KindDataHi : KindDataLo;
                     rd_en        = 1'b1;
                  end else if ({1'b0, pos_ff} == data_end) begin
                     slot_in.kind = KindCrcLo;
                  end else begin
                     slot_in.kind = KindCrcHi;
                     slot_in.last = 1'b1;
                  end
                  if (slot_in.last) begin
                     pend_in = 1'b0;
                     pos_in  = 8'd0;
                  end else begin
                     pos_in = pos_ff + 8'd1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // byte stage: pick the byte and run the reply CRC in order
   always_comb begin
      logic [15:0] word;
      logic [7:0]  b;
      logic [15:0] base;
      word = (slot_ff.in_range && vq_ff) ? ram_q : 16'd0;
      case (slot_ff.kind)
         KindConst:  b = slot_ff.const_byte;
         KindDataHi: b = word[15:8];
         KindDataLo: b = word[7:0];
         KindCrcLo:  b = reply_crc_ff[7:0];
         KindCrcHi:  b = reply_crc_ff[15:8];
         default:    b = 8'd0;
      endcase
      base         = slot_ff.first ? CrcInit : reply_crc_ff;
      reply_crc_in = reply_crc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (slot_adv) begin
         rsp_valid_in   = 1'b1;
         rsp_in.tx_byte = b;
         rsp_in.last    = slot_ff.last;
         if (slot_ff.kind != KindCrcLo && slot_ff.kind != KindCrcHi) begin
            reply_crc_in = crc_feed(base, b);
         end
      end
   end

   mbrtu_ram #(
      .WIDTH(16),
      .DEPTH(STORE_WORDS)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_payload.store_value),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff      <= 8'd1;
         silence_ticks_ff <= 8'd5;
         awaiting_ff      <= 1'b1;
         frame_len_ff     <= 9'd0;
         sil_cnt_ff       <= 8'd0;
         timer_ff         <= 1'b0;
         crc_run_ff       <= CrcInit;
         tail0_ff         <= 8'd0;
         tail1_ff         <= 8'd0;
         pend_ff          <= 1'b0;
         pos_ff           <= 8'd0;
         raddr_byte_ff    <= 8'd0;
         rstart_ff        <= 16'd0;
         rcount_ff        <= 8'd0;
         reply_crc_ff     <= CrcInit;
         slot_vld_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         wvalid_ff        <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CsrDeviceAddress: dev_addr_ff      <= csr_data;
               CsrSilenceTicks:  silence_ticks_ff <= csr_data;
               default: ;
            endcase
         end
         awaiting_ff   <= awaiting_in;
         frame_len_ff  <= frame_len_in;
         sil_cnt_ff    <= sil_cnt_in;
         timer_ff      <= timer_in;
         crc_run_ff    <= crc_run_in;
         tail0_ff      <= tail0_in;
         tail1_ff      <= tail1_in;
         pend_ff       <= pend_in;
         pos_ff        <= pos_in;
         raddr_byte_ff <= raddr_byte_in;
         rstart_ff     <= rstart_in;
         rcount_ff     <= rcount_in;
         reply_crc_ff  <= reply_crc_in;
         slot_vld_ff   <= slot_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (wr_en) begin
            wvalid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 6; i++) hdr_ff[i] <= hdr_in[i];
      slot_ff <= slot_in;
      rsp_ff  <= rsp_in;
      if (rd_en) begin
         vq_ff <= wvalid_ff[rd_addr];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ sv/mbrtu_checker.sv @@
module mbrtu_checker
   import mbrtu_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   a_reset_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_reset_req: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("request stalled after reset");

   // the request side backs up only behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result changed");

endmodule

bind modbus_rtu_read_register_slave_top mbrtu_checker u_mbrtu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_payload(rsp_payload)
);

@@ bench/testbench.sv @@
module testbench;
   import mbrtu_pkg::*;

   localparam int IdleLimit = 5000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;
   logic    csr_we;
   logic    csr_index;
   logic [7:0] csr_data;

   modbus_rtu_read_register_slave_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   // slave shadow state
   logic [7:0]  dev_addr;
   logic [7:0]  quiet_ticks;
   bit          awaiting;
   int          frame_len;
   logic [7:0]  head_bytes [6];
   logic [7:0]  quiet_count;
   bit          timer_on;
   logic [15:0] rx_crc;
   logic [7:0]  tail_bytes [2];
   logic [15:0] reg_store [StoreWordsDef];
   bit          reply_busy;
   int          reply_pos;
   logic [15:0] reply_crc;
   logic [7:0]  reply_addr;
   logic [15:0] reply_start;
   logic [7:0]  reply_count;

   rsp_type reply_bytes_q [$];

   int idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   int fails = 0;
   int items_sent = 0;
   int bytes_seen = 0;
   int replies_seen = 0;
   int quiet_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [15:0] mb_crc(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
      return r;
   endfunction

   function automatic void judge_frame();
      logic [15:0] count;
      if (frame_len < 8) return;
      if (rx_crc[7:0] != tail_bytes[0] || rx_crc[15:8] != tail_bytes[1]) return;
      if (head_bytes[0] != dev_addr || head_bytes[1] != FuncReadHolding) return;
      count = {head_bytes[4], head_bytes[5]};
      if (count > MaxReadCountDef) return;
      reply_addr  = dev_addr;
      reply_start = {head_bytes[2], head_bytes[3]};
      reply_count = count[7:0];
      reply_pos   = 0;
      reply_crc   = 16'hFFFF;
      reply_busy  = 1;
   endfunction

   function automatic void predict(req_type it);
      bit take;
      int data_end, addr;
      logic [15:0] w;
      rsp_type r;
      case (it.mode)
         ModeRxByte: begin
            take = 1;
            if (awaiting) begin
               if (it.data_byte != dev_addr) take = 0;
               else begin
                  awaiting = 0;
                  frame_len = 0;
                  rx_crc = 16'hFFFF;
                  tail_bytes[0] = 0;
                  tail_bytes[1] = 0;
               end
            end else if (frame_len >= MaxFrameBytesDef) take = 0;
            if (take) begin
               if (frame_len >= 2) rx_crc = mb_crc(rx_crc, tail_bytes[0]);
               tail_bytes[0] = tail_bytes[1];
               tail_bytes[1] = it.data_byte;
               if (frame_len < 6) head_bytes[frame_len] = it.data_byte;
               frame_len++;
               quiet_count = 0;
               timer_on = 1;
            end
         end
         ModeTick: begin
            if (timer_on) begin
               if (quiet_count < 8'd255) quiet_count++;
               if (quiet_count >= quiet_ticks) begin
                  timer_on = 0;
                  quiet_count = 0;
                  awaiting = 1;
                  judge_frame();
                  frame_len = 0;
               end
            end
         end
         ModeWrite: reg_store[it.store_index] = it.store_value;
         default: begin
            if (reply_busy) begin
               data_end = 3 + 2 * reply_count;
               r.last = 0;
               if (reply_pos == 0) r.tx_byte = reply_addr;
               else if (reply_pos == 1) r.tx_byte = FuncReadHolding;
               else if (reply_pos == 2) r.tx_byte = 8'(2 * reply_count);
               else if (reply_pos < data_end) begin
                  addr = int'(reply_start) + ((reply_pos - 3) >> 1);
                  w = (addr < StoreWordsDef) ? reg_store[addr] : 16'h0000;
                  r.tx_byte = ((reply_pos - 3) & 1) ? w[7:0] : w[15:8];
               end else if (reply_pos == data_end) r.tx_byte = reply_crc[7:0];
               else begin
                  r.tx_byte = reply_crc[15:8];
                  r.last = 1;
               end
               if (reply_pos < data_end) reply_crc = mb_crc(reply_crc, r.tx_byte);
               if (r.last) begin
                  reply_busy = 0;
                  reply_pos = 0;
               end else reply_pos++;
               reply_bytes_q.push_back(r);
            end
         end
      endcase
   endfunction

   // result checking
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         bytes_seen++;
         if (reply_bytes_q.size() == 0) begin
            $error("unexpected reply byte %h", rsp_payload.tx_byte);
            fails++;
         end else begin
            want = reply_bytes_q.pop_front();
            if (rsp_payload.tx_byte !== want.tx_byte) begin
               $error("tx_byte: expected %h, got %h", want.tx_byte, rsp_payload.tx_byte);
               fails++;
            end
            if (rsp_payload.last !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_payload.last);
               fails++;
            end
            if (want.last) replies_seen++;
         end
      end
   end

   // result stall, with an optional long hold
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else rsp_stall = ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
         $display("watchdog: no transfer for %0d cycles", IdleLimit);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic req_type mk_item(logic [1:0] m, logic [7:0] b, logic [6:0] i,
                                       logic [15:0] v);
      req_type it;
      it.mode = m;
      it.data_byte = b;
      it.store_index = i;
      it.store_value = v;
      return it;
   endfunction

   task automatic send_item(req_type it);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_payload = it;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      predict(it);
      items_sent++;
   endtask

   task automatic send_byte(logic [7:0] b);
      send_item(mk_item(ModeRxByte, b, 7'($urandom), 16'($urandom)));
   endtask

   task automatic send_tick();
      send_item(mk_item(ModeTick, 8'($urandom), 7'($urandom), 16'($urandom)));
   endtask

   task automatic send_slot();
      send_item(mk_item(ModeTxSlot, 8'($urandom), 7'($urandom), 16'($urandom)));
   endtask

   task automatic store_write(logic [6:0] i, logic [15:0] v);
      send_item(mk_item(ModeWrite, 8'($urandom), i, v));
   endtask

   task automatic send_silence();
      for (int k = 0; k < quiet_ticks; k++) send_tick();
   endtask

   // address, function, start, count, CRC; optionally spoil the CRC and mix in
   // writes and slots between bytes
   task automatic send_frame(logic [7:0] a, logic [7:0] fn, logic [15:0] s,
                             logic [15:0] c, bit bad_crc, bit mixed);
      logic [7:0] fb [8];
      logic [15:0] crc;
      fb[0] = a; fb[1] = fn; fb[2] = s[15:8]; fb[3] = s[7:0];
      fb[4] = c[15:8]; fb[5] = c[7:0];
      crc = 16'hFFFF;
      for (int k = 0; k < 6; k++) crc = mb_crc(crc, fb[k]);
      if (bad_crc) crc ^= 16'(1 << $urandom_range(15));
      fb[6] = crc[7:0]; fb[7] = crc[15:8];
      for (int k = 0; k < 8; k++) begin
         send_byte(fb[k]);
         if (mixed && $urandom_range(99) < 15) begin
            if ($urandom_range(1)) store_write(7'($urandom), 16'($urandom));
            else send_slot();
         end
      end
      send_silence();
   endtask

   task automatic drain_reply(bit mixed);
      while (reply_busy) begin
         send_slot();
         if (mixed && $urandom_range(99) < 10) store_write(7'($urandom), 16'($urandom));
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (reply_bytes_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [7:0] val);
      wait_drained();
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CsrDeviceAddress) dev_addr = val;
      else quiet_ticks = val;
   endtask

   task automatic test_directed();
      idle_pct = 0;
      stall_pct = 0;
      store_write(7'd0, 16'hFFFF);
      store_write(7'd127, 16'h0000);
      store_write(7'd1, 16'h8001);
      send_tick();
      send_slot();
      send_byte(8'hFF);
      send_frame(dev_addr, FuncReadHolding, 16'd0, 16'd2, 0, 0);
      drain_reply(0);
      send_frame(dev_addr, FuncReadHolding, 16'd5, 16'd0, 0, 0);
      drain_reply(0);
      // largest count is answered; take its head, a later read replaces it
      send_frame(dev_addr, FuncReadHolding, 16'd100, 16'd120, 0, 0);
      repeat (4) send_slot();
      send_frame(dev_addr, FuncReadHolding, 16'd0, 16'd121, 0, 0);
      send_frame(dev_addr, FuncWriteSingle, 16'd0, 16'd1, 0, 0);
      send_frame(dev_addr, FuncWriteMulti, 16'd0, 16'd1, 0, 0);
      send_frame(dev_addr, FuncReadHolding, 16'd0, 16'd1, 1, 0);
      send_frame(dev_addr, FuncReadHolding, 16'hFFFF, 16'd1, 0, 0);
      drain_reply(0);
      send_slot();
      // too short to be checked
      send_byte(dev_addr);
      send_byte(FuncReadHolding);
      send_byte(8'h00);
      send_silence();
      // a new read restarts the reply under way
      send_frame(dev_addr, FuncReadHolding, 16'd0, 16'd4, 0, 0);
      repeat (3) send_slot();
      send_frame(dev_addr, FuncReadHolding, 16'd126, 16'd3, 0, 0);
      repeat (4) send_slot();
      store_write(7'd127, 16'h1234);
      drain_reply(0);
   endtask

   task automatic test_long_frame();
      send_byte(dev_addr);
      for (int k = 0; k < 260; k++) send_byte(8'($urandom));
      send_silence();
      drain_reply(0);
   endtask

   task automatic test_config();
      write_reg(CsrDeviceAddress, 8'h00);
      send_frame(8'h00, FuncReadHolding, 16'd0, 16'd2, 0, 0);
      drain_reply(0);
      write_reg(CsrDeviceAddress, 8'hFF);
      write_reg(CsrSilenceTicks, 8'd40);
      send_frame(8'hFF, FuncReadHolding, 16'd1, 16'd1, 0, 0);
      drain_reply(0);
      write_reg(CsrSilenceTicks, 8'd1);
      send_frame(8'hFF, FuncReadHolding, 16'd3, 16'd2, 0, 0);
      drain_reply(0);
   endtask

   task automatic random_frame();
      logic [7:0] fn;
      logic [15:0] cnt;
      int pick;
      pick = $urandom_range(99);
      fn = (pick < 80) ? FuncReadHolding :
           (pick < 88) ? FuncWriteSingle :
           (pick < 96) ? FuncWriteMulti : 8'($urandom);
      pick = $urandom_range(99);
      cnt = (pick < 85) ? 16'($urandom_range(8)) :
            (pick < 92) ? 16'($urandom_range(120)) : 16'($urandom);
      send_frame(dev_addr, fn, 16'($urandom_range(135)), cnt,
                 $urandom_range(99) < 10, 1);
      drain_reply(1);
   endtask

   task automatic test_random();
      int idle_set [4] = '{0, 73, 0, 28};
      int stall_set [4] = '{0, 0, 73, 28};
      int goal;
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(CsrDeviceAddress, 8'($urandom));
         write_reg(CsrSilenceTicks, 8'($urandom_range(1, 4)));
         idle_pct = idle_set[ph];
         stall_pct = stall_set[ph];
         goal = items_sent + 30;
         while (items_sent < goal) begin
            if ($urandom_range(99) < 80) random_frame();
            else begin
               repeat ($urandom_range(1, 6))
                  send_item(mk_item(2'($urandom), 8'($urandom), 7'($urandom),
                                    16'($urandom)));
               drain_reply(1);
            end
         end
      end
      idle_pct = 0;
      stall_pct = 0;
   endtask

   task automatic test_backpressure();
      wait_drained();
      send_frame(dev_addr, FuncReadHolding, 16'd0, 16'd20, 0, 0);
      hold_left = 400;
      drain_reply(0);
      // pause until every byte is out
      wait_drained();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = 1'b0;
      csr_data = 8'h00;
      dev_addr = 8'd1;
      quiet_ticks = 8'd5;
      awaiting = 1;
      frame_len = 0;
      foreach (head_bytes[k]) head_bytes[k] = 0;
      quiet_count = 0;
      timer_on = 0;
      rx_crc = 16'hFFFF;
      tail_bytes[0] = 0;
      tail_bytes[1] = 0;
      foreach (reg_store[k]) reg_store[k] = 0;
      reply_busy = 0;
      reply_pos = 0;
      reply_crc = 16'hFFFF;
      reply_addr = 0;
      reply_start = 0;
      reply_count = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_long_frame();
      test_config();
      test_random();
      test_backpressure();
      wait_drained();

      $display("covered %0d transfers in, %0d reply bytes in %0d replies,", items_sent,
               bytes_seen, replies_seen);
      $display("over address and silence settings, idle and stall mixes and a long hold");
      if (fails == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
